// ===== rtl/core/cit_pkg.sv =====
package cit_pkg;

   localparam int unsigned CmdWidth    = 2;
   localparam int unsigned PosWidth    = 4;
   localparam int unsigned ItemWidth   = 32;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned CountWidth  = 5;

   typedef enum logic [CmdWidth-1:0] {
      CMD_APPEND = 2'd0,
      CMD_SET    = 2'd1,
      CMD_GET    = 2'd2,
      CMD_DELETE = 2'd3
   } command_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

// ===== rtl/core/cit_ram.sv =====
module cit_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/compacting_item_table.sv =====
// Ordered table of up to DEPTH 32-bit items held in one single-port-write RAM.
// Each request transaction carries append, set, get or delete and yields exactly
// one response transaction with the read value, a status and the entry count.
// Requests are taken one at a time. Append, set, delete of the last entry and
// any out-of-range or full-table command answer from ST_IDLE. Get waits in ST_GET
// for the registered RAM read; any other delete runs in ST_SHIFT, where the RAM
// moves one entry down per cycle, reading the next entry while writing this one.
// A finished response waits in an output register; the next request is taken
// in the same cycle the response is taken or once it has been taken.
module compacting_item_table #(
   parameter int unsigned DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_position,
   input  logic [31:0] req_item_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_value,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_count
);

   localparam int unsigned AW  = $clog2(DEPTH);
   localparam int unsigned CW  = $clog2(DEPTH + 1);
   localparam int unsigned XW  = (CW > cit_pkg::PosWidth) ? CW : cit_pkg::PosWidth;
   localparam int unsigned CW1 = CW + 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_GET   = 3'b010,
      ST_SHIFT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;

   logic                           rsp_valid_ff;
   logic [cit_pkg::ItemWidth-1:0]  rsp_read_value_ff;
   logic [cit_pkg::StatusWidth-1:0] rsp_status_ff;
   logic [cit_pkg::CountWidth-1:0] rsp_count_ff;

   logic                            load;
   logic [cit_pkg::ItemWidth-1:0]   ld_value;
   cit_pkg::status_type             ld_status;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;

   logic          out_free, req_accept, pos_ok;
   logic [XW-1:0] pos_x, cnt_x;

   cit_ram #(
      .WIDTH (cit_pkg::ItemWidth),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign pos_x      = XW'(req_position);
   assign cnt_x      = XW'(count_ff);
   assign pos_ok     = pos_x < cnt_x;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      load      = 1'b0;
      ld_value  = '0;
      ld_status = cit_pkg::STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_command)
                  cit_pkg::CMD_APPEND: begin
                     load = 1'b1;
                     if (CW1'(count_ff) >= CW1'(DEPTH)) begin
                        ld_status = cit_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(count_ff);
                        wr_data  = req_item_value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  cit_pkg::CMD_SET: begin
                     load = 1'b1;
                     if (!pos_ok) begin
                        ld_status = cit_pkg::STATUS_RANGE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(req_position);
                        wr_data = req_item_value;
                     end
                  end
                  cit_pkg::CMD_GET: begin
                     if (!pos_ok) begin
                        load      = 1'b1;
                        ld_status = cit_pkg::STATUS_RANGE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_position);
                        state_in = ST_GET;
                     end
                  end
                  default: begin
                     if (!pos_ok) begin
                        load      = 1'b1;
                        ld_status = cit_pkg::STATUS_RANGE;
                     end else if (pos_x == cnt_x - XW'(1)) begin
                        // last entry: nothing to move
                        load     = 1'b1;
                        count_in = count_ff - CW'(1);
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_position) + AW'(1);
                        idx_in   = AW'(req_position);
                        state_in = ST_SHIFT;
                     end
                  end
               endcase
            end
         end
         ST_GET: begin
            load     = 1'b1;
            ld_value = rd_data;
            state_in = ST_IDLE;
         end
         ST_SHIFT: begin
            // rd_data holds entry idx+1; write it down into idx
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            if (CW1'(idx_ff) + CW1'(2) < CW1'(count_ff)) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + AW'(2);
               idx_in  = idx_ff + AW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (load) begin
         rsp_read_value_ff <= ld_value;
         rsp_status_ff     <= ld_status;
         rsp_count_ff      <= cit_pkg::CountWidth'(count_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      CW1'(count_ff) <= CW1'(DEPTH))
      else $error("entry count beyond capacity");

   a_busy_output_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while a multi-cycle transaction runs");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (CW1'(idx_ff) + CW1'(1) < CW1'(count_ff)))
      else $error("shift reads beyond the stored entries");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_command == cit_pkg::CMD_APPEND)
         && (CW1'(count_ff) < CW1'(DEPTH)))
      |=> (count_ff == $past(count_ff) + CW'(1)) && rsp_valid_ff)
      else $error("append did not grow the table");

   a_shift_ends_shrunk: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHIFT) && (state_in == ST_IDLE))
      |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("delete did not shrink the table");

endmodule
